>>> hdl/sled_pkg.sv
`default_nettype none

package sled_pkg;

  // action codes
  localparam logic [2:0] ACT_TICK   = 3'd0;
  localparam logic [2:0] ACT_STATE  = 3'd1;
  localparam logic [2:0] ACT_MANUAL = 3'd2;
  localparam logic [2:0] ACT_OFF    = 3'd3;
  localparam logic [2:0] ACT_AUTO   = 3'd4;

  // device state codes
  localparam logic [3:0] DEV_WIFI       = 4'd2;
  localparam logic [3:0] DEV_IDLE       = 4'd3;
  localparam logic [3:0] DEV_CONNECTING = 4'd4;
  localparam logic [3:0] DEV_LISTENING  = 4'd5;
  localparam logic [3:0] DEV_SPEAKING   = 4'd6;
  localparam logic [3:0] DEV_UPGRADING  = 4'd7;
  localparam logic [3:0] DEV_ACTIVATING = 4'd8;
  localparam logic [3:0] DEV_FATAL      = 4'd10;
  localparam logic [3:0] DEV_NOTIFYING  = 4'd11;

  // color slots, same order as config registers 0..6
  localparam int          NUM_SLOTS      = 7;
  localparam logic [2:0] SLOT_IDLE       = 3'd0;
  localparam logic [2:0] SLOT_CONNECTING = 3'd1;
  localparam logic [2:0] SLOT_LISTENING  = 3'd2;
  localparam logic [2:0] SLOT_SPEAKING   = 3'd3;
  localparam logic [2:0] SLOT_NOTIFYING  = 3'd4;
  localparam logic [2:0] SLOT_ERROR      = 3'd5;
  localparam logic [2:0] SLOT_UPGRADING  = 3'd6;

  // config register index of the breath mode bits
  localparam logic [2:0] REG_BREATH_MODE = 3'd7;

  localparam logic [6:0] BRIGHT_MAX   = 7'd100;
  localparam logic [6:0] BRIGHT_FLOOR = 7'd2;
  localparam int         PHASE_W      = 8;

  // x / 100 for x <= 25500: x * ceil(2^19 / 100) >> 19
  localparam logic [27:0] RECIP_100 = 28'd5243;

  typedef logic [23:0] rgb_t;

  typedef struct packed {
    logic [14:0] r;
    logic [14:0] g;
    logic [14:0] b;
  } prod_t;

  typedef struct packed {
    logic [2:0] slot;
    logic       force_breath;
  } slot_sel_t;

  function automatic logic [7:0] div100(input logic [14:0] x);
    logic [27:0] m;
    m = {13'd0, x} * RECIP_100;
    return m[26:19];
  endfunction

  function automatic rgb_t scale_rgb(input prod_t p);
    return {div100(p.r), div100(p.g), div100(p.b)};
  endfunction

  function automatic slot_sel_t slot_of(input logic [3:0] st);
    slot_sel_t s;
    s.force_breath = 1'b0;
    case (st)
      DEV_IDLE:       s.slot = SLOT_IDLE;
      DEV_CONNECTING: s.slot = SLOT_CONNECTING;
      DEV_LISTENING:  s.slot = SLOT_LISTENING;
      DEV_SPEAKING:   s.slot = SLOT_SPEAKING;
      DEV_NOTIFYING:  s.slot = SLOT_NOTIFYING;
      DEV_FATAL:      s.slot = SLOT_ERROR;
      DEV_UPGRADING,
      DEV_ACTIVATING: s.slot = SLOT_UPGRADING;
      DEV_WIFI: begin
        s.slot         = SLOT_CONNECTING;
        s.force_breath = 1'b1;
      end
      default: begin
        s.slot         = SLOT_IDLE;
        s.force_breath = 1'b1;
      end
    endcase
    return s;
  endfunction

endpackage

`default_nettype wire

>>> hdl/status_led_breath_controller.sv
`default_nettype none

// Status LED color controller. Each request is one action: a breath tick, a
// device-state change, a manual color (with brightness percent, clamped to
// 100), off, or a return to auto mode; each request yields exactly one result
// with the displayed color, a changed flag (set only when the color differs
// from the one shown before), and the breathing / auto status. Per-state
// colors and the breath mode bits sit in config registers 0..7 and are
// written through the cfg_ port, ready out of reset. The user must write them
// only while the block is idle; the block does not enforce it. Both ready
// outputs stay low while reset is held. It takes one request per clock unless
// out_ready stalls; a request passes the input register, one pass of logic
// and the result register. Brightness scaling uses a byte-by-percent multiply
// ahead of a register and a reciprocal multiply for the divide by 100 behind
// it: the manual product is formed on the way into the input register, and
// the product for the next breath tick is kept in a state register.
module status_led_breath_controller #(
  parameter int BREATH_STEP = 2,
  parameter int BREATH_PEAK = 100
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // config write channel
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [23:0] cfg_data,
  // request channel
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [2:0]  in_action,
  input  wire logic [3:0]  in_device_state,
  input  wire logic [7:0]  in_red_in,
  input  wire logic [7:0]  in_green_in,
  input  wire logic [7:0]  in_blue_in,
  input  wire logic [6:0]  in_bright_in,
  // result channel
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [7:0]       out_red_out,
  output logic [7:0]       out_green_out,
  output logic [7:0]       out_blue_out,
  output logic             out_changed,
  output logic             out_is_breathing,
  output logic             out_is_auto
);
  import sled_pkg::*;

  // ---------------------------------------------------------------------
  // breath triangle: phase advance with wrap, brightness with floor
  // ---------------------------------------------------------------------
  function automatic logic [PHASE_W-1:0] phase_adv(input logic [PHASE_W-1:0] ph);
    logic [PHASE_W:0] p;
    p = {1'b0, ph} + (PHASE_W+1)'(BREATH_STEP);
    if (p > (PHASE_W+1)'(2 * BREATH_PEAK))
      p = '0;
    return p[PHASE_W-1:0];
  endfunction

  function automatic logic [6:0] bright_of(input logic [PHASE_W-1:0] p);
    logic [PHASE_W-1:0] b;
    if (p <= PHASE_W'(BREATH_PEAK))
      b = p;
    else
      b = PHASE_W'(2 * BREATH_PEAK) - p;
    if (b < PHASE_W'(BRIGHT_FLOOR))
      b = PHASE_W'(BRIGHT_FLOOR);
    return b[6:0];
  endfunction

  // ---------------------------------------------------------------------
  // config registers
  // ---------------------------------------------------------------------
  rgb_t       cfg_color_r [NUM_SLOTS];
  logic [6:0] mode_r;

  assign cfg_ready = rst_n;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_SLOTS; i++)
        cfg_color_r[i] <= '0;
      mode_r <= '0;
    end else if (cfg_valid) begin
      if (cfg_index == REG_BREATH_MODE)
        mode_r <= cfg_data[6:0];
      else
        cfg_color_r[cfg_index] <= cfg_data;
    end
  end

  // ---------------------------------------------------------------------
  // input register; manual product formed on the way in
  // ---------------------------------------------------------------------
  logic       s1_valid_r;
  logic [2:0] s1_action_r;
  logic [3:0] s1_state_r;
  prod_t      s1_prod_r;
  prod_t      in_prod;
  logic [6:0] in_bright_clamp;
  logic       fire;

  assign in_bright_clamp = (in_bright_in > BRIGHT_MAX) ? BRIGHT_MAX : in_bright_in;

  sled_mul u_in_mul (
    .color  ({in_red_in, in_green_in, in_blue_in}),
    .bright (in_bright_clamp),
    .prod   (in_prod)
  );

  // stage 1 moves into the result register when that is empty or draining
  assign fire     = s1_valid_r && (!out_valid || out_ready);
  assign in_ready = rst_n && (!s1_valid_r || fire);

  always_ff @(posedge clk) begin
    if (!rst_n)
      s1_valid_r <= 1'b0;
    else if (in_ready)
      s1_valid_r <= in_valid;
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_action_r <= in_action;
      s1_state_r  <= in_device_state;
      s1_prod_r   <= in_prod;
    end
  end

  // ---------------------------------------------------------------------
  // controller state
  // ---------------------------------------------------------------------
  rgb_t               shown_r, shown_nxt;
  rgb_t               bcolor_r, bcolor_nxt;
  logic [PHASE_W-1:0] phase_r, phase_nxt;
  logic               breathing_r, breathing_nxt;
  logic               manual_r, manual_nxt;
  prod_t              tick_prod_r;   // bcolor_r times brightness of the next tick
  prod_t              tick_prod_nxt;

  slot_sel_t  sel;
  rgb_t       sel_color;
  logic       sel_breathe;
  logic       do_apply;
  logic       show_en;
  rgb_t       show_col;
  logic       chg;

  assign sel         = slot_of(s1_state_r);
  assign sel_color   = cfg_color_r[sel.slot];
  assign sel_breathe = sel.force_breath || mode_r[sel.slot];

  always_comb begin
    shown_nxt     = shown_r;
    bcolor_nxt    = bcolor_r;
    phase_nxt     = phase_r;
    breathing_nxt = breathing_r;
    manual_nxt    = manual_r;
    show_en       = 1'b0;
    show_col      = '0;
    do_apply      = 1'b0;
    case (s1_action_r)
      ACT_TICK: begin
        if (breathing_r) begin
          phase_nxt = phase_adv(phase_r);
          show_en   = 1'b1;
          show_col  = scale_rgb(tick_prod_r);
        end
      end
      ACT_STATE: begin
        do_apply = !manual_r;
      end
      ACT_AUTO: begin
        manual_nxt = 1'b0;
        do_apply   = 1'b1;
      end
      ACT_MANUAL: begin
        manual_nxt    = 1'b1;
        breathing_nxt = 1'b0;
        show_en       = 1'b1;
        show_col      = scale_rgb(s1_prod_r);
      end
      ACT_OFF: begin
        manual_nxt    = 1'b1;
        breathing_nxt = 1'b0;
        show_en       = 1'b1;
        show_col      = '0;
      end
      default: begin
      end
    endcase

    if (do_apply) begin
      if (sel_breathe) begin
        // breathing keeps its phase if already running
        bcolor_nxt = sel_color;
        if (!breathing_r) begin
          breathing_nxt = 1'b1;
          phase_nxt     = '0;
        end
      end else begin
        breathing_nxt = 1'b0;
        show_en       = 1'b1;
        show_col      = sel_color;
      end
    end

    chg = show_en && (show_col != shown_r);
    if (chg)
      shown_nxt = show_col;
  end

  // next-tick product from the state that this request leaves behind
  sled_mul u_tick_mul (
    .color  (bcolor_nxt),
    .bright (bright_of(phase_adv(phase_nxt))),
    .prod   (tick_prod_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      shown_r     <= '0;
      bcolor_r    <= '0;
      phase_r     <= '0;
      breathing_r <= 1'b0;
      manual_r    <= 1'b0;
      tick_prod_r <= '0;
    end else if (fire) begin
      shown_r     <= shown_nxt;
      bcolor_r    <= bcolor_nxt;
      phase_r     <= phase_nxt;
      breathing_r <= breathing_nxt;
      manual_r    <= manual_nxt;
      tick_prod_r <= tick_prod_nxt;
    end
  end

  // ---------------------------------------------------------------------
  // result register
  // ---------------------------------------------------------------------
  logic       out_valid_r;
  rgb_t       out_color_r;
  logic       out_changed_r;
  logic       out_breathing_r;
  logic       out_auto_r;

  always_ff @(posedge clk) begin
    if (!rst_n)
      out_valid_r <= 1'b0;
    else if (fire)
      out_valid_r <= 1'b1;
    else if (out_ready)
      out_valid_r <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_color_r     <= shown_nxt;
      out_changed_r   <= chg;
      out_breathing_r <= breathing_nxt;
      out_auto_r      <= !manual_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_red_out      = out_color_r[23:16];
  assign out_green_out    = out_color_r[15:8];
  assign out_blue_out     = out_color_r[7:0];
  assign out_changed      = out_changed_r;
  assign out_is_breathing = out_breathing_r;
  assign out_is_auto      = out_auto_r;

  // ---------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------
  a_changed_means_new : assert property (@(posedge clk) disable iff (!rst_n)
    fire && chg |=> shown_r != $past(shown_r))
    else $error("changed flagged but shown color kept");

  a_state_holds : assert property (@(posedge clk) disable iff (!rst_n)
    !fire |=> $stable(shown_r) && $stable(phase_r) && $stable(breathing_r))
    else $error("controller state moved without a request");

  a_manual_static : assert property (@(posedge clk) disable iff (!rst_n)
    manual_r |-> !breathing_r)
    else $error("breathing under manual override");

  a_phase_range : assert property (@(posedge clk) disable iff (!rst_n)
    phase_r <= PHASE_W'(2 * BREATH_PEAK))
    else $error("breath phase past wrap point");

endmodule

`default_nettype wire

>>> hdl/sled_mul.sv
`default_nettype none

// per-channel color byte times brightness percent
module sled_mul (
  input  wire logic [23:0]   color,
  input  wire logic [6:0]    bright,
  output sled_pkg::prod_t    prod
);
  import sled_pkg::*;

  assign prod.r = {7'd0, color[23:16]} * {8'd0, bright};
  assign prod.g = {7'd0, color[15:8]}  * {8'd0, bright};
  assign prod.b = {7'd0, color[7:0]}   * {8'd0, bright};

endmodule

`default_nettype wire

>>> tb/status_led_breath_controller_tb.sv
`default_nettype none

module status_led_breath_controller_tb;
  import sled_pkg::*;

  // Breath triangle parameters, passed to the DUT so both sides agree.
  localparam int STEP_PCT = 2;
  localparam int PEAK_PCT = 100;
  // Divisor of the brightness scaling; fixed, independent of the peak.
  localparam int PCT_FULL = 100;

  // Action codes the block ignores (no name in the package).
  localparam logic [2:0] ACT_RSVD5 = 3'd5;
  localparam logic [2:0] ACT_RSVD7 = 3'd7;

  // Device states that fall through to "breathe in the idle color".
  localparam logic [3:0] DEV_UNKNOWN    = 4'd0;
  localparam logic [3:0] DEV_STARTING   = 4'd1;
  localparam logic [3:0] DEV_AUDIO_TEST = 4'd9;
  localparam logic [3:0] DEV_CODE_MAX   = 4'd15;

  localparam int NUM_PHASES      = 8;
  localparam int ITEMS_PER_PHASE = 250;
  localparam int DIR_CFG_AT      = 11;   // directed row index where registers get set
  localparam int DRAIN_CYCLES    = 4;    // covers the input and result registers, plus margin
  localparam int STALL_LIMIT     = 2000; // cycles with no handshake at all

  typedef struct packed {
    logic [2:0] action;
    logic [3:0] dev;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [6:0] bright;
  } led_req_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       changed;
    logic       breathing;
    logic       auto_mode;
  } led_view_t;

  // One directed row: the request, and a typed-in result where it is obvious.
  typedef struct {
    led_req_t  q;
    bit        known;
    led_view_t v;
  } led_row_t;

  // ---------------------------------------------------------------------------
  // Clock, reset, DUT
  // ---------------------------------------------------------------------------
  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  always #4 clk = ~clk;

  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [23:0] cfg_data  = '0;

  logic        in_valid        = 1'b0;
  logic        in_ready;
  logic [2:0]  in_action       = '0;
  logic [3:0]  in_device_state = '0;
  logic [7:0]  in_red_in       = '0;
  logic [7:0]  in_green_in     = '0;
  logic [7:0]  in_blue_in      = '0;
  logic [6:0]  in_bright_in    = '0;

  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  out_red_out;
  logic [7:0]  out_green_out;
  logic [7:0]  out_blue_out;
  logic        out_changed;
  logic        out_is_breathing;
  logic        out_is_auto;

  status_led_breath_controller #(
    .BREATH_STEP(STEP_PCT),
    .BREATH_PEAK(PEAK_PCT)
  ) DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_action        (in_action),
    .in_device_state  (in_device_state),
    .in_red_in        (in_red_in),
    .in_green_in      (in_green_in),
    .in_blue_in       (in_blue_in),
    .in_bright_in     (in_bright_in),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_red_out      (out_red_out),
    .out_green_out    (out_green_out),
    .out_blue_out     (out_blue_out),
    .out_changed      (out_changed),
    .out_is_breathing (out_is_breathing),
    .out_is_auto      (out_is_auto)
  );

  // ---------------------------------------------------------------------------
  // LED controller shadow: registers and state as the block should hold them.
  // Everything starts at zero, same as the block after reset.
  // ---------------------------------------------------------------------------
  rgb_t       slot_rgb [NUM_SLOTS] = '{default: '0};
  logic [6:0] breath_mask = '0;
  rgb_t       cur_rgb     = '0;   // color on the LEDs
  rgb_t       breath_rgb  = '0;   // color the triangle is applied to
  logic [7:0] breath_pos  = '0;   // position on the 0..2*peak triangle
  bit         breath_on   = 1'b0;
  bit         manual_on   = 1'b0;
  bit         upd         = 1'b0; // current request changed the shown color

  // Expected results, oldest first.
  led_view_t pending_views [$];

  // Values for the next register load.
  rgb_t       next_rgb [NUM_SLOTS];
  logic [6:0] next_mask;

  int idle_pct        = 0;  // chance of an idle gap on either side
  int err_count       = 0;
  int requests_sent   = 0;
  int results_checked = 0;
  int color_updates   = 0;
  int breath_wraps    = 0;
  int settings_loaded = 0;
  int stuck_cycles    = 0;

  // Per-channel scale by pct/100, pct clamped to 100.
  function automatic rgb_t dim_rgb(rgb_t c, int unsigned pct);
    rgb_t        s;
    int unsigned p;
    int          k;
    p = (pct > BRIGHT_MAX) ? BRIGHT_MAX : pct;
    for (k = 0; k < 3; k++) s[8*k +: 8] = 8'((int'(c[8*k +: 8]) * p) / PCT_FULL);
    return s;
  endfunction

  function automatic void show_rgb(rgb_t c);
    if (c != cur_rgb) begin
      cur_rgb = c;
      upd     = 1'b1;
    end
  endfunction

  // Loading a breath color only restarts the triangle when not already breathing.
  function automatic void begin_breath(rgb_t c);
    breath_rgb = c;
    if (!breath_on) begin
      breath_on  = 1'b1;
      breath_pos = '0;
    end
  endfunction

  function automatic void apply_slot(logic [2:0] s);
    if (breath_mask[s]) begin
      begin_breath(slot_rgb[s]);
    end else begin
      breath_on = 1'b0;
      show_rgb(slot_rgb[s]);
    end
  endfunction

  function automatic void apply_dev(logic [3:0] st);
    case (st)
      DEV_IDLE:       apply_slot(SLOT_IDLE);
      DEV_CONNECTING: apply_slot(SLOT_CONNECTING);
      DEV_LISTENING:  apply_slot(SLOT_LISTENING);
      DEV_SPEAKING:   apply_slot(SLOT_SPEAKING);
      DEV_NOTIFYING:  apply_slot(SLOT_NOTIFYING);
      DEV_FATAL:      apply_slot(SLOT_ERROR);
      DEV_UPGRADING,
      DEV_ACTIVATING: apply_slot(SLOT_UPGRADING);
      // wifi setup breathes in the connecting color whatever the mode bits say
      DEV_WIFI:       begin_breath(slot_rgb[SLOT_CONNECTING]);
      // unknown, starting, audio test and undefined codes: idle color, breathing
      default:        begin_breath(slot_rgb[SLOT_IDLE]);
    endcase
  endfunction

  // One breath tick: advance, wrap past twice the peak, floor the brightness.
  function automatic void step_breath();
    int unsigned pos;
    int unsigned pct;
    if (!breath_on) return;
    pos = breath_pos + STEP_PCT;
    if (pos > 2 * PEAK_PCT) begin
      pos = 0;
      breath_wraps++;
    end
    breath_pos = 8'(pos);
    pct = (pos <= PEAK_PCT) ? pos : 2 * PEAK_PCT - pos;
    if (pct < BRIGHT_FLOOR) pct = BRIGHT_FLOOR;
    show_rgb(dim_rgb(breath_rgb, pct));
  endfunction

  // Apply one request to the shadow and return the result the block must give.
  function automatic led_view_t led_next_view(led_req_t q);
    led_view_t v;
    upd = 1'b0;
    case (q.action)
      ACT_TICK:  step_breath();
      ACT_STATE: if (!manual_on) apply_dev(q.dev);
      ACT_MANUAL: begin
        manual_on = 1'b1;
        breath_on = 1'b0;
        show_rgb(dim_rgb({q.red, q.green, q.blue}, q.bright));
      end
      ACT_OFF: begin
        manual_on = 1'b1;
        breath_on = 1'b0;
        show_rgb('0);
      end
      ACT_AUTO: begin
        manual_on = 1'b0;
        apply_dev(q.dev);
      end
      default: ;  // reserved codes leave everything alone
    endcase
    if (upd) color_updates++;
    v = {cur_rgb, upd, breath_on, !manual_on};
    return v;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic led_req_t req(logic [2:0] a, logic [3:0] d, rgb_t c, logic [6:0] pct);
    return {a, d, c, pct};
  endfunction

  function automatic led_view_t view(rgb_t c, bit ch, bit br, bit au);
    return {c, ch, br, au};
  endfunction

  // Color components lean toward the rails now and then.
  function automatic logic [7:0] pick_byte();
    if ($urandom_range(7) == 0) return $urandom_range(1) ? 8'hFF : 8'h00;
    return 8'($urandom);
  endfunction

  // Random request. Ticks take tick_pct percent so the triangle gets walked
  // end to end; the rest: state changes, auto, manual, off and reserved codes.
  function automatic led_req_t make_request(int tick_pct);
    led_req_t q;
    int       roll;
    q.dev   = 4'($urandom_range(15));
    q.red   = pick_byte();
    q.green = pick_byte();
    q.blue  = pick_byte();
    case ($urandom_range(7))
      0:       q.bright = 7'd0;
      1:       q.bright = BRIGHT_MAX;
      2:       q.bright = BRIGHT_MAX + 7'd1;
      3:       q.bright = 7'h7F;
      default: q.bright = 7'($urandom_range(127));
    endcase
    roll = $urandom_range(99);
    if (roll < tick_pct) begin
      q.action = ACT_TICK;
    end else begin
      roll = $urandom_range(99);
      if (roll < 45)      q.action = ACT_STATE;
      else if (roll < 62) q.action = ACT_AUTO;
      else if (roll < 82) q.action = ACT_MANUAL;
      else if (roll < 92) q.action = ACT_OFF;
      else                q.action = 3'($urandom_range(ACT_RSVD7, ACT_RSVD5));
    end
    return q;
  endfunction

  // Push one request through the input channel. Valid is left high on return
  // so back-to-back requests never drop it; a gap lowers it first.
  task automatic send_request(led_req_t q, bit known, led_view_t want);
    led_view_t predicted;
    if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(3, 1)) @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_action       <= q.action;
    in_device_state <= q.dev;
    in_red_in       <= q.red;
    in_green_in     <= q.green;
    in_blue_in      <= q.blue;
    in_bright_in    <= q.bright;
    do @(posedge clk); while (!in_ready);
    // Shadow always advances; typed-in rows override what gets checked.
    predicted = led_next_view(q);
    pending_views.push_back(known ? want : predicted);
    requests_sent++;
  endtask

  task automatic write_reg(logic [2:0] idx, logic [23:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    if (idx == REG_BREATH_MODE) breath_mask = data[6:0];
    else                        slot_rgb[idx] = data;
  endtask

  // Load next_rgb / next_mask into all eight registers.
  task automatic program_regs();
    int s;
    for (s = 0; s < NUM_SLOTS; s++) write_reg(3'(s), next_rgb[s]);
    write_reg(REG_BREATH_MODE, {17'd0, next_mask});
    cfg_valid <= 1'b0;
    @(posedge clk);
    settings_loaded++;
  endtask

  // Stop sending and let every outstanding result come back.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_views.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Result side: random backpressure and the scoreboard check.
  // ---------------------------------------------------------------------------
  function automatic void check_field(string name, int want, int got);
    if (want != got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      err_count++;
    end
  endfunction

  int stall_left = 0;

  always @(posedge clk) begin : result_side
    led_view_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      // out_ready read here is the value that held during the cycle just ended
      if (out_valid && out_ready) begin
        if (pending_views.size() == 0) begin
          $error("result arrived with no request pending");
          err_count++;
        end else begin
          want = pending_views.pop_front();
          check_field("red_out",      want.red,       out_red_out);
          check_field("green_out",    want.green,     out_green_out);
          check_field("blue_out",     want.blue,      out_blue_out);
          check_field("changed",      want.changed,   out_changed);
          check_field("is_breathing", want.breathing, out_is_breathing);
          check_field("is_auto",      want.auto_mode, out_is_auto);
          results_checked++;
        end
      end
      // random stall bursts on the result side
      if (stall_left != 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
        stall_left = $urandom_range(2, 0);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Watchdog: cycles in a row with no handshake on any channel.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      stuck_cycles <= 0;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  initial begin
    wait (rst_n);
    while (stuck_cycles < STALL_LIMIT) @(posedge clk);
    $display("watchdog: no handshake for %0d cycles, %0d results outstanding",
             STALL_LIMIT, pending_views.size());
    $display("TB_ERROR");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  led_row_t dir_rows [$];

  initial begin
    int k;
    int ph;
    int s;
    int tick_pct;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Directed rows. The first block runs with reset registers (all colors
    // zero, nothing breathing), so results are typed in directly.
    // tick while not breathing: nothing happens
    dir_rows.push_back('{req(ACT_TICK, DEV_UNKNOWN, 24'h0, 7'd0), 1'b1,
                         view(24'h000000, 1'b0, 1'b0, 1'b1)});
    // static idle in black: same color, no change flagged
    dir_rows.push_back('{req(ACT_STATE, DEV_IDLE, 24'h0, 7'd0), 1'b1,
                         view(24'h000000, 1'b0, 1'b0, 1'b1)});
    // unknown state starts breathing; color stays until the next tick
    dir_rows.push_back('{req(ACT_STATE, DEV_UNKNOWN, 24'h0, 7'd0), 1'b1,
                         view(24'h000000, 1'b0, 1'b1, 1'b1)});
    // reserved action code
    dir_rows.push_back('{req(ACT_RSVD7, DEV_CODE_MAX, 24'hFFFFFF, 7'h7F), 1'b1,
                         view(24'h000000, 1'b0, 1'b1, 1'b1)});
    // manual white at 127 percent clamps to 100
    dir_rows.push_back('{req(ACT_MANUAL, DEV_UNKNOWN, 24'hFFFFFF, 7'h7F), 1'b1,
                         view(24'hFFFFFF, 1'b1, 1'b0, 1'b0)});
    // state change under manual override is dropped
    dir_rows.push_back('{req(ACT_STATE, DEV_FATAL, 24'h0, 7'd0), 1'b1,
                         view(24'hFFFFFF, 1'b0, 1'b0, 1'b0)});
    // zero brightness
    dir_rows.push_back('{req(ACT_MANUAL, DEV_UNKNOWN, 24'hFF0080, 7'd0), 1'b1,
                         view(24'h000000, 1'b1, 1'b0, 1'b0)});
    // off while already dark
    dir_rows.push_back('{req(ACT_OFF, DEV_UNKNOWN, 24'h0, 7'd0), 1'b1,
                         view(24'h000000, 1'b0, 1'b0, 1'b0)});
    dir_rows.push_back('{req(ACT_MANUAL, DEV_UNKNOWN, 24'h804001, BRIGHT_MAX), 1'b1,
                         view(24'h804001, 1'b1, 1'b0, 1'b0)});
    dir_rows.push_back('{req(ACT_OFF, DEV_UNKNOWN, 24'h0, 7'd0), 1'b1,
                         view(24'h000000, 1'b1, 1'b0, 1'b0)});
    // back to auto in wifi setup: forced breathing
    dir_rows.push_back('{req(ACT_AUTO, DEV_WIFI, 24'h0, 7'd0), 1'b1,
                         view(24'h000000, 1'b0, 1'b1, 1'b1)});
    // From here registers hold distinct colors; the shadow predicts.
    dir_rows.push_back('{req(ACT_STATE, DEV_IDLE, 24'h0, 7'd0), 1'b0, '0});
    dir_rows.push_back('{req(ACT_TICK, DEV_IDLE, 24'h0, 7'd0), 1'b0, '0});
    dir_rows.push_back('{req(ACT_TICK, DEV_IDLE, 24'h0, 7'd0), 1'b0, '0});
    dir_rows.push_back('{req(ACT_STATE, DEV_LISTENING, 24'h0, 7'd0), 1'b0, '0});
    dir_rows.push_back('{req(ACT_STATE, DEV_SPEAKING, 24'h0, 7'd0), 1'b0, '0});
    dir_rows.push_back('{req(ACT_TICK, DEV_SPEAKING, 24'h0, 7'd0), 1'b0, '0});
    dir_rows.push_back('{req(ACT_STATE, DEV_ACTIVATING, 24'h0, 7'd0), 1'b0, '0});
    dir_rows.push_back('{req(ACT_STATE, DEV_UPGRADING, 24'h0, 7'd0), 1'b0, '0});
    dir_rows.push_back('{req(ACT_STATE, DEV_NOTIFYING, 24'h0, 7'd0), 1'b0, '0});
    dir_rows.push_back('{req(ACT_STATE, DEV_AUDIO_TEST, 24'h0, 7'd0), 1'b0, '0});
    dir_rows.push_back('{req(ACT_TICK, DEV_AUDIO_TEST, 24'h0, 7'd0), 1'b0, '0});
    dir_rows.push_back('{req(ACT_MANUAL, DEV_IDLE, 24'h7F80FF, BRIGHT_MAX + 7'd1),
                         1'b0, '0});
    dir_rows.push_back('{req(ACT_AUTO, DEV_CODE_MAX, 24'h0, 7'd0), 1'b0, '0});
    dir_rows.push_back('{req(ACT_STATE, DEV_STARTING, 24'h0, 7'd0), 1'b0, '0});
    dir_rows.push_back('{req(ACT_STATE, DEV_CONNECTING, 24'h0, 7'd0), 1'b0, '0});
    dir_rows.push_back('{req(ACT_STATE, DEV_FATAL, 24'h0, 7'd0), 1'b0, '0});
    dir_rows.push_back('{req(ACT_RSVD5, DEV_IDLE, 24'h0, 7'd0), 1'b0, '0});

    idle_pct = 25;
    for (k = 0; k < dir_rows.size(); k++) begin
      if (k == DIR_CFG_AT) begin
        wait_idle();
        next_rgb[SLOT_IDLE]       = 24'hFFFFFF;
        next_rgb[SLOT_CONNECTING] = 24'h123456;
        next_rgb[SLOT_LISTENING]  = 24'h00FF00;
        next_rgb[SLOT_SPEAKING]   = 24'hFF0000;
        next_rgb[SLOT_NOTIFYING]  = 24'h0000FF;
        next_rgb[SLOT_ERROR]      = 24'h808080;
        next_rgb[SLOT_UPGRADING]  = 24'hA5A5A5;
        next_mask = 7'b0101011;   // idle, connecting, speaking, error breathe
        program_regs();
      end
      send_request(dir_rows[k].q, dir_rows[k].known, dir_rows[k].v);
    end

    // Random phases. Each starts from an empty pipeline (the sender holds off
    // until every result is back), then reloads all registers. The first
    // three are the extremes: white everywhere breathing, black static,
    // white static. Phase 3 and the last run with no gaps on either side.
    for (ph = 0; ph < NUM_PHASES; ph++) begin
      wait_idle();
      for (s = 0; s < NUM_SLOTS; s++) begin
        case (ph)
          0, 2:    next_rgb[s] = 24'hFFFFFF;
          1:       next_rgb[s] = 24'h000000;
          default: begin
            case ($urandom_range(7))
              0:       next_rgb[s] = 24'h000000;
              1:       next_rgb[s] = 24'hFFFFFF;
              default: next_rgb[s] = 24'($urandom);
            endcase
          end
        endcase
      end
      case (ph)
        0:       next_mask = 7'h7F;
        1, 2:    next_mask = 7'h00;
        default: next_mask = 7'($urandom);
      endcase
      program_regs();

      idle_pct = (ph == 3 || ph == NUM_PHASES - 1) ? 0 : $urandom_range(40, 10);
      tick_pct = (ph == 0) ? 85 : $urandom_range(80, 30);
      repeat (ITEMS_PER_PHASE) send_request(make_request(tick_pct), 1'b0, '0);
    end

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d requests, checked %0d results, over %0d register loads.",
             requests_sent, results_checked, settings_loaded);
    $display("Shown color changed %0d times; breath triangle wrapped %0d times.",
             color_updates, breath_wraps);
    if (err_count == 0 && pending_views.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire

>>> sim.f
hdl/sled_pkg.sv
hdl/sled_mul.sv
hdl/status_led_breath_controller.sv
tb/status_led_breath_controller_tb.sv
